FILE: hdl/svo_pkg.sv
// ============================================================================
// svo_pkg
// Shared types and constants for the servo slew and duty unit.
// ============================================================================
package svo_pkg;

    // Field widths
    localparam int ANGLE_W = 8;
    localparam int PULSE_W = 15;
    localparam int FREQ_W  = 10;
    localparam int DBITS_W = 5;
    localparam int DUTY_W  = 20;
    localparam int CIDX_W  = 2;

    localparam int DEFAULT_MAX_DUTY_BITS = 20;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX = 8'd180;

    // Register reset values
    localparam logic [PULSE_W-1:0] MIN_PULSE_RST = 15'd500;
    localparam logic [PULSE_W-1:0] MAX_PULSE_RST = 15'd2500;
    localparam logic [FREQ_W-1:0]  PWM_FREQ_RST  = 10'd50;
    localparam logic [DBITS_W-1:0] DUTY_BITS_RST = 5'd16;

    // Division by 180 as multiply by reciprocal: exact for products below 2^23
    localparam int                RECIP_W     = 24;
    localparam logic [RECIP_W-1:0] RECIP_180  = 24'd11930465;
    localparam int                RECIP_SHIFT = 31;

    // Microseconds per second, and the quotient width below the saturation limit
    localparam int                US_W      = 20;
    localparam logic [US_W-1:0]   US_PER_S  = 20'd1000000;
    localparam int                QUO_W     = DUTY_W;

    // Division by one million: drop six low bits, then divide by 15625 with a
    // reciprocal estimate from the top bits and one correction step
    localparam int                DIV_SHIFT  = 6;
    localparam int                ODD_W      = 14;
    localparam logic [ODD_W-1:0]  ODD_DIV    = 14'd15625;
    localparam int                OREC_W     = 21;
    localparam logic [OREC_W-1:0] RECIP_ODD  = 21'd1099511;
    localparam int                OREC_SHIFT = 20;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MIN_PULSE = 2'd0,
        CFG_MAX_PULSE = 2'd1,
        CFG_PWM_FREQ  = 2'd2,
        CFG_DUTY_BITS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic               status;
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] target;
    } svo_item_t;

    typedef struct packed {
        logic [PULSE_W-1:0] min_pulse;
        logic [PULSE_W-1:0] max_pulse;
        logic [FREQ_W-1:0]  pwm_freq;
        logic [DBITS_W-1:0] duty_bits;
    } svo_cfg_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SCALE,
        BK_RATE,
        BK_FULL,
        BK_RANGE,
        BK_DIVIDE,
        BK_ADJUST,
        BK_DONE
    } bk_state_t;

endpackage

FILE: hdl/svo_front.sv
// ============================================================================
// svo_front
// Accepts control ticks, steps the servo angle and queues the tick result.
// ============================================================================
module svo_front import svo_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ANGLE_W-1:0] s_target_deg,
    input  logic [ANGLE_W-1:0] s_tolerance_deg,
    input  logic [ANGLE_W-1:0] s_step_deg,
    input  logic               q_full,
    output logic               q_push,
    output svo_item_t          q_item
);

    logic [ANGLE_W-1:0] angle_reg;
    logic [ANGLE_W-1:0] angle_next;
    logic [ANGLE_W-1:0] gap;
    logic               reached;
    logic [ANGLE_W:0]   up_sum;
    logic [ANGLE_W-1:0] up_angle;
    logic [ANGLE_W-1:0] down_angle;
    logic [ANGLE_W-1:0] step_angle;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        gap        = (s_target_deg >= angle_reg) ? (s_target_deg - angle_reg)
                                                 : (angle_reg - s_target_deg);
        reached    = (gap <= s_tolerance_deg);
        up_sum     = {1'b0, angle_reg} + {1'b0, s_step_deg};
        up_angle   = (up_sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : up_sum[ANGLE_W-1:0];
        down_angle = (angle_reg < s_step_deg) ? '0 : (angle_reg - s_step_deg);
        if (reached) begin
            step_angle = angle_reg;
        end else if (s_target_deg > angle_reg) begin
            step_angle = up_angle;
        end else begin
            step_angle = down_angle;
        end
        angle_next = q_push ? step_angle : angle_reg;

        q_item.status = reached;
        q_item.angle  = step_angle;
        q_item.target = s_target_deg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
        end else begin
            angle_reg <= angle_next;
        end
    end

endmodule

FILE: hdl/svo_fifo.sv
// ============================================================================
// svo_fifo
// Short command queue that decouples the tick front end from the duty engine.
// ============================================================================
module svo_fifo import svo_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  svo_item_t push_item,
    input  logic      pop,
    output svo_item_t pop_item,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    svo_item_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: hdl/svo_back.sv
// ============================================================================
// svo_back
// Duty engine: pulse interpolation, rate products and a reciprocal divider.
// ============================================================================
module svo_back import svo_pkg::*; #(
    parameter int MAX_DUTY_BITS = DEFAULT_MAX_DUTY_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  svo_cfg_t           cfg,
    input  logic               q_empty,
    input  svo_item_t          q_item,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [ANGLE_W-1:0] m_angle_now,
    output logic [ANGLE_W-1:0] m_target_echo,
    output logic [DUTY_W-1:0]  m_duty_word
);

    localparam int FULL_W  = MAX_DUTY_BITS;
    localparam int SCALE_W = ANGLE_W + PULSE_W;
    localparam int RPROD_W = SCALE_W + RECIP_W;
    localparam int RATE_W  = PULSE_W + FREQ_W;
    localparam int PROD_W  = RATE_W + FULL_W;
    localparam int LIM_W   = US_W + QUO_W;
    localparam int REM_W   = (PROD_W > LIM_W) ? PROD_W : LIM_W;
    localparam int Y_W     = LIM_W - DIV_SHIFT;
    localparam int EPROD_W = QUO_W + OREC_W;
    localparam int QPROD_W = QUO_W + ODD_W;
    localparam int CAP_W   = (FULL_W > DUTY_W) ? FULL_W : DUTY_W;
    localparam int CMP_W   = (QUO_W > CAP_W) ? QUO_W : CAP_W;

    localparam logic [REM_W-1:0] D_LIM  = REM_W'(US_PER_S) << QUO_W;
    localparam logic [REM_W-1:0] ODD_X1 = REM_W'(ODD_DIV);
    localparam logic [REM_W-1:0] ODD_X2 = REM_W'(ODD_DIV) << 1;
    localparam logic [REM_W-1:0] ODD_X3 = REM_W'(3 * ODD_DIV);
    localparam logic [CAP_W-1:0] DUTY_CAP = CAP_W'({DUTY_W{1'b1}});

    bk_state_t          state_reg, state_next;
    logic               m_valid_reg, m_valid_next;
    svo_item_t          item_reg, item_next;
    logic               down_reg, down_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [PULSE_W-1:0] pulse_reg, pulse_next;
    logic [RATE_W-1:0]  rate_reg, rate_next;
    logic [FULL_W-1:0]  full_reg, full_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic               m_status_reg, m_status_next;
    logic [ANGLE_W-1:0] m_angle_reg, m_angle_next;
    logic [ANGLE_W-1:0] m_target_reg, m_target_next;
    logic [DUTY_W-1:0]  m_duty_reg, m_duty_next;

    logic [PULSE_W-1:0] span;
    logic [RPROD_W-1:0] recip_prod;
    logic [PULSE_W-1:0] quot180;
    logic [DBITS_W-1:0] bits_sat;
    logic [Y_W-1:0]     y_low;
    logic [QUO_W-1:0]   y_top;
    logic [EPROD_W-1:0] est_prod;
    logic [QUO_W-1:0]   q_est;
    logic [QPROD_W-1:0] q_prod;
    logic [CAP_W-1:0]   full_ext;
    logic [CAP_W-1:0]   cap;
    logic [CMP_W-1:0]   quo_ext, cap_ext, duty_ext;
    logic               out_free;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_angle_now   = m_angle_reg;
    assign m_target_echo = m_target_reg;
    assign m_duty_word   = m_duty_reg;

    always_comb begin
        span       = (cfg.max_pulse < cfg.min_pulse) ? (cfg.min_pulse - cfg.max_pulse)
                                                     : (cfg.max_pulse - cfg.min_pulse);
        recip_prod = RPROD_W'(scale_reg) * RPROD_W'(RECIP_180);
        quot180    = recip_prod[RECIP_SHIFT +: PULSE_W];
        bits_sat   = (cfg.duty_bits > DBITS_W'(MAX_DUTY_BITS)) ? DBITS_W'(MAX_DUTY_BITS)
                                                               : cfg.duty_bits;
        // product over 64, and its top bits for the quotient estimate
        y_low      = rem_reg[DIV_SHIFT +: Y_W];
        y_top      = rem_reg[DIV_SHIFT + ODD_W +: QUO_W];
        est_prod   = EPROD_W'(y_top) * EPROD_W'(RECIP_ODD);
        q_est      = est_prod[OREC_SHIFT +: QUO_W];
        q_prod     = QPROD_W'(quo_reg) * QPROD_W'(ODD_DIV);
        full_ext   = CAP_W'(full_reg);
        cap        = (full_ext < DUTY_CAP) ? full_ext : DUTY_CAP;
        quo_ext    = CMP_W'(quo_reg);
        cap_ext    = CMP_W'(cap);
        duty_ext   = (quo_ext > cap_ext) ? cap_ext : quo_ext;
        out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        state_next    = state_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        item_next     = item_reg;
        down_next     = (cfg.max_pulse < cfg.min_pulse);
        scale_next    = scale_reg;
        pulse_next    = pulse_reg;
        rate_next     = rate_reg;
        full_next     = full_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        m_status_next = m_status_reg;
        m_angle_next  = m_angle_reg;
        m_target_next = m_target_reg;
        m_duty_next   = m_duty_reg;
        q_pop         = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                down_next = down_reg;
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    down_next  = (cfg.max_pulse < cfg.min_pulse);
                    scale_next = SCALE_W'(q_item.angle) * SCALE_W'(span);
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE: begin
                down_next  = down_reg;
                pulse_next = down_reg ? (cfg.min_pulse - quot180) : (cfg.min_pulse + quot180);
                state_next = BK_RATE;
            end
            BK_RATE: begin
                down_next  = down_reg;
                rate_next  = RATE_W'(pulse_reg) * RATE_W'(cfg.pwm_freq);
                full_next  = {FULL_W{1'b1}} >> (DBITS_W'(MAX_DUTY_BITS) - bits_sat);
                state_next = BK_FULL;
            end
            BK_FULL: begin
                down_next  = down_reg;
                rem_next   = REM_W'(PROD_W'(rate_reg) * PROD_W'(full_reg));
                state_next = BK_RANGE;
            end
            BK_RANGE: begin
                down_next = down_reg;
                if (rem_reg >= D_LIM) begin
                    // quotient beyond any cap: saturate
                    quo_next   = '1;
                    state_next = BK_DONE;
                end else begin
                    // estimate never exceeds the quotient and trails it by at most two
                    quo_next   = q_est;
                    state_next = BK_DIVIDE;
                end
            end
            BK_DIVIDE: begin
                down_next  = down_reg;
                rem_next   = REM_W'(y_low - q_prod);
                state_next = BK_ADJUST;
            end
            BK_ADJUST: begin
                down_next = down_reg;
                if (rem_reg >= ODD_X3) begin
                    quo_next = quo_reg + QUO_W'(3);
                end else if (rem_reg >= ODD_X2) begin
                    quo_next = quo_reg + QUO_W'(2);
                end else if (rem_reg >= ODD_X1) begin
                    quo_next = quo_reg + QUO_W'(1);
                end
                state_next = BK_DONE;
            end
            BK_DONE: begin
                down_next = down_reg;
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = item_reg.status;
                    m_angle_next  = item_reg.angle;
                    m_target_next = item_reg.target;
                    m_duty_next   = duty_ext[DUTY_W-1:0];
                    state_next    = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        down_reg     <= down_next;
        scale_reg    <= scale_next;
        pulse_reg    <= pulse_next;
        rate_reg     <= rate_next;
        full_reg     <= full_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        m_status_reg <= m_status_next;
        m_angle_reg  <= m_angle_next;
        m_target_reg <= m_target_next;
        m_duty_reg   <= m_duty_next;
    end

endmodule

FILE: hdl/servo_angle_slew_and_duty_unit.sv
// ============================================================================
// servo_angle_slew_and_duty_unit
// Servo slew-rate limiter with PWM duty word generation.
// ============================================================================
// Each beat on the s_ channel is one control tick (target, tolerance, step).
// The front end updates the held servo angle in the cycle the beat is taken:
// hold and report reached when within tolerance, else step toward the target,
// clamped to 0..180. The tick result waits in a two-entry queue while the
// duty engine turns the angle into a duty word: pulse width by interpolation
// between the two limits, times full scale and frequency, divided by one
// million through a reciprocal estimate and one correction step, saturated to
// full scale. One beat on the m_ channel carries each result. The duty engine
// sets the rate, taking one tick at a time through its steps (load, divide
// by 180, two products, range check with quotient estimate, remainder,
// correction, output) and holding at output while the previous result waits;
// a product past the saturation limit skips remainder and correction.
// The front end keeps taking ticks until the queue is full, and the output
// register lets the engine start the next tick while a result waits.
// Registers sit on the cfg_ channel (always ready): 0 min pulse us,
// 1 max pulse us, 2 PWM frequency Hz, 3 duty resolution bits; write them
// only while no tick is in flight.
// ============================================================================
module servo_angle_slew_and_duty_unit import svo_pkg::*; #(
    parameter int MAX_DUTY_BITS = DEFAULT_MAX_DUTY_BITS
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [PULSE_W-1:0] cfg_data,
    // control ticks
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ANGLE_W-1:0] s_target_deg,
    input  logic [ANGLE_W-1:0] s_tolerance_deg,
    input  logic [ANGLE_W-1:0] s_step_deg,
    // tick results
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_status,
    output logic [ANGLE_W-1:0] m_angle_now,
    output logic [ANGLE_W-1:0] m_target_echo,
    output logic [DUTY_W-1:0]  m_duty_word
);

    svo_cfg_t  cfg_reg, cfg_next;
    svo_item_t push_item, pop_item;
    logic      push, pop, q_full, q_empty;

    // Config writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_MIN_PULSE: cfg_next.min_pulse = cfg_data;
                CFG_MAX_PULSE: cfg_next.max_pulse = cfg_data;
                CFG_PWM_FREQ:  cfg_next.pwm_freq  = cfg_data[FREQ_W-1:0];
                CFG_DUTY_BITS: cfg_next.duty_bits = cfg_data[DBITS_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse <= MIN_PULSE_RST;
            cfg_reg.max_pulse <= MAX_PULSE_RST;
            cfg_reg.pwm_freq  <= PWM_FREQ_RST;
            cfg_reg.duty_bits <= DUTY_BITS_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front end: take the tick, advance the angle, queue the result.
    svo_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_target_deg    (s_target_deg),
        .s_tolerance_deg (s_tolerance_deg),
        .s_step_deg      (s_step_deg),
        .q_full          (q_full),
        .q_push          (push),
        .q_item          (push_item)
    );

    // Queue: lets the front keep taking ticks while the divider runs.
    svo_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: compute the duty word and hold the result beat.
    svo_back #(
        .MAX_DUTY_BITS (MAX_DUTY_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .q_empty       (q_empty),
        .q_item        (pop_item),
        .q_pop         (pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_angle_now   (m_angle_now),
        .m_target_echo (m_target_echo),
        .m_duty_word   (m_duty_word)
    );

endmodule

FILE: hdl/svo_checker.sv
// ============================================================================
// svo_checker
// Port-level checks for the servo slew and duty unit.
// ============================================================================
module svo_checker import svo_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_status,
    input logic [ANGLE_W-1:0] m_angle_now,
    input logic [ANGLE_W-1:0] m_target_echo,
    input logic [DUTY_W-1:0]  m_duty_word
);

    // Reset leaves no result beat pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // The angle never leaves 0..180.
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_angle_now <= ANGLE_MAX))
        else $error("angle beyond 180");

    // A stalled result beat stays up.
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped");

    // A stalled result beat keeps its payload.
    a_payload_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_status) && $stable(m_angle_now)
                                && $stable(m_target_echo) && $stable(m_duty_word))
        else $error("result payload changed while stalled");

endmodule

bind servo_angle_slew_and_duty_unit svo_checker u_svo_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_angle_now   (m_angle_now),
    .m_target_echo (m_target_echo),
    .m_duty_word   (m_duty_word)
);

FILE: dv/tb_servo_angle_slew_and_duty_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_servo_angle_slew_and_duty_unit
// Self-checking bench: a clocked driver sends control ticks from a queue, and a
// clocked monitor compares every result beat with a local slew and duty
// calculator. Runs directed corner ticks and random move sequences under
// several register settings and three idling modes, with one long output stall.
// ============================================================================
module tb_servo_angle_slew_and_duty_unit;
    import svo_pkg::*;

    localparam int DUTY_BITS_LIM = DEFAULT_MAX_DUTY_BITS;
    localparam int SETTLE_CYCLES = 40;       // several tick latencies
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_AT       = 1100;     // input beat count that starts the long stall
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        logic [ANGLE_W-1:0] target;
        logic [ANGLE_W-1:0] tolerance;
        logic [ANGLE_W-1:0] step;
    } tick_cmd_t;

    typedef struct packed {
        logic               status;
        logic [ANGLE_W-1:0] angle;
        logic [ANGLE_W-1:0] target;
        logic [DUTY_W-1:0]  duty;
    } tick_result_t;

    // ------------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic               aclk;
    logic               aresetn         = 1'b0;
    logic               cfg_valid       = 1'b0;
    logic               cfg_ready;
    cfg_index_t         cfg_index       = CFG_MIN_PULSE;
    logic [PULSE_W-1:0] cfg_data        = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [ANGLE_W-1:0] s_target_deg    = '0;
    logic [ANGLE_W-1:0] s_tolerance_deg = '0;
    logic [ANGLE_W-1:0] s_step_deg      = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic               m_status;
    logic [ANGLE_W-1:0] m_angle_now;
    logic [ANGLE_W-1:0] m_target_echo;
    logic [DUTY_W-1:0]  m_duty_word;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    tick_cmd_t    tick_cmds[$];           // ticks waiting to be sent
    tick_result_t tick_results_due[$];    // predicted results, oldest first

    // Shadow of the servo angle and the four registers
    logic [ANGLE_W-1:0] servo_angle = '0;
    logic [PULSE_W-1:0] min_us      = MIN_PULSE_RST;
    logic [PULSE_W-1:0] max_us      = MAX_PULSE_RST;
    logic [FREQ_W-1:0]  freq_hz     = PWM_FREQ_RST;
    logic [DBITS_W-1:0] res_bits    = DUTY_BITS_RST;

    int unsigned src_idle_pct  = 24;
    int unsigned sink_idle_pct = 78;
    int unsigned s_beats       = 0;
    int unsigned mismatches    = 0;
    int unsigned hold_left     = 0;
    logic        hold_done     = 1'b0;
    int unsigned cycle_cnt     = 0;

    servo_angle_slew_and_duty_unit #(
        .MAX_DUTY_BITS (DUTY_BITS_LIM)
    ) DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_target_deg    (s_target_deg),
        .s_tolerance_deg (s_tolerance_deg),
        .s_step_deg      (s_step_deg),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_angle_now     (m_angle_now),
        .m_target_echo   (m_target_echo),
        .m_duty_word     (m_duty_word)
    );

    // 2 ns clock
    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Duty calculator: interpolate the pulse width, scale by full scale and
    // frequency, divide by one million, then saturate twice.
    // ------------------------------------------------------------------------
    function automatic logic [DUTY_W-1:0] duty_at(input logic [ANGLE_W-1:0] ang);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] pulse;
        logic [63:0] full;
        logic [63:0] duty;
        int unsigned nbits;
        lo = 64'(min_us);
        hi = 64'(max_us);
        // Reversed limits interpolate downward from min
        if (hi >= lo) begin
            pulse = lo + (64'(ang) * (hi - lo)) / 64'(ANGLE_MAX);
        end else begin
            pulse = lo - (64'(ang) * (lo - hi)) / 64'(ANGLE_MAX);
        end
        // Clip resolution to the build limit; zero bits give zero full scale
        nbits = res_bits;
        if (nbits > DUTY_BITS_LIM) begin
            nbits = DUTY_BITS_LIM;
        end
        full = (64'd1 << nbits) - 64'd1;
        duty = (pulse * full * 64'(freq_hz)) / 64'(US_PER_S);
        if (duty > full) begin
            duty = full;
        end
        if (duty > 64'((1 << DUTY_W) - 1)) begin
            duty = 64'((1 << DUTY_W) - 1);
        end
        return duty[DUTY_W-1:0];
    endfunction

    // Advance the shadow angle by one tick and return the result it reports
    function automatic tick_result_t advance_servo(input tick_cmd_t cmd);
        logic [ANGLE_W-1:0] ang;
        logic [ANGLE_W-1:0] gap;
        logic [ANGLE_W:0]   sum;
        tick_result_t       res;
        ang  = servo_angle;
        gap  = (cmd.target >= ang) ? cmd.target - ang : ang - cmd.target;
        res.status = 1'b0;
        if (gap <= cmd.tolerance) begin
            // Within tolerance: hold and report reached
            res.status = 1'b1;
        end else if (cmd.target > ang) begin
            // Step up; clamp at 180 without 8-bit wrap
            sum = {1'b0, ang} + {1'b0, cmd.step};
            ang = (sum > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : sum[ANGLE_W-1:0];
        end else begin
            // Step down; clamp at zero
            ang = (ang < cmd.step) ? '0 : ang - cmd.step;
        end
        servo_angle = ang;
        res.angle  = ang;
        res.target = cmd.target;
        res.duty   = duty_at(ang);
        return res;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Tick driver: record each accepted beat in the predictor, then offer the
    // next pending tick unless this cycle idles. Hold the payload while
    // s_ready is low.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_ticks
        tick_cmd_t cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                cmd.target    = s_target_deg;
                cmd.tolerance = s_tolerance_deg;
                cmd.step      = s_step_deg;
                tick_results_due.push_back(advance_servo(cmd));
                s_beats <= s_beats + 1;
            end
            if (!s_valid || s_ready) begin
                if (tick_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    cmd = tick_cmds.pop_front();
                    s_valid         <= 1'b1;
                    s_target_deg    <= cmd.target;
                    s_tolerance_deg <= cmd.tolerance;
                    s_step_deg      <= cmd.step;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: compare each result beat with the oldest prediction,
    // then pick the next m_ready (random idling, forced low during the hold).
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : check_results
        tick_result_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (tick_results_due.size() == 0) begin
                    $display("%0t ns: result beat with none expected, actual angle %0d duty %0d",
                             $time, m_angle_now, m_duty_word);
                    mismatches++;
                end else begin
                    due = tick_results_due.pop_front();
                    check_field("status", due.status, m_status);
                    check_field("angle_now", due.angle, m_angle_now);
                    check_field("target_echo", due.target, m_target_echo);
                    check_field("duty_word", due.duty, m_duty_word);
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    // Long output stall: once enough ticks went in, hold m_ready low for a
    // fixed stretch so the queue fills and s_ready drops.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && s_beats >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_servo_angle_slew_and_duty_unit failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic queue_tick(input int unsigned tgt, input int unsigned tol,
                              input int unsigned stp);
        tick_cmd_t cmd;
        cmd.target    = tgt[ANGLE_W-1:0];
        cmd.tolerance = tol[ANGLE_W-1:0];
        cmd.step      = stp[ANGLE_W-1:0];
        tick_cmds.push_back(cmd);
    endtask

    // Mostly repeated commands so the servo actually travels, settles and
    // holds; now and then a fully random tick as noise.
    task automatic queue_moves(input int unsigned count);
        int unsigned left;
        int unsigned reps;
        int unsigned tgt;
        int unsigned tol;
        int unsigned stp;
        int unsigned pick;
        left = count;
        while (left != 0) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_tick($urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 255));
                left--;
            end else begin
                tgt  = ($urandom_range(0, 9) == 0) ? $urandom_range(181, 255)
                                                   : $urandom_range(0, 180);
                pick = $urandom_range(0, 9);
                tol  = (pick < 6) ? $urandom_range(0, 5)
                     : (pick < 9) ? $urandom_range(0, 20) : $urandom_range(0, 255);
                pick = $urandom_range(0, 9);
                stp  = (pick == 0) ? 0
                     : (pick < 8) ? $urandom_range(1, 20) : $urandom_range(21, 255);
                reps = $urandom_range(1, 16);
                if (reps > left) begin
                    reps = left;
                end
                repeat (reps) queue_tick(tgt, tol, stp);
                left -= reps;
            end
        end
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input cfg_index_t idx, input logic [PULSE_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_MIN_PULSE: min_us   = val;
            CFG_MAX_PULSE: max_us   = val;
            CFG_PWM_FREQ:  freq_hz  = val[FREQ_W-1:0];
            CFG_DUTY_BITS: res_bits = val[DBITS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input int unsigned lo_us, input int unsigned hi_us,
                                 input int unsigned hz, input int unsigned nbits);
        write_reg(CFG_MIN_PULSE, PULSE_W'(lo_us));
        write_reg(CFG_MAX_PULSE, PULSE_W'(hi_us));
        write_reg(CFG_PWM_FREQ, PULSE_W'(hz));
        write_reg(CFG_DUTY_BITS, PULSE_W'(nbits));
    endtask

    // Let every queued tick go in and every result come out, then settle
    task automatic wait_drained();
        while (tick_cmds.size() != 0 || s_valid || tick_results_due.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic run_setting(input int unsigned lo_us, input int unsigned hi_us,
                               input int unsigned hz, input int unsigned nbits,
                               input int unsigned count);
        apply_setting(lo_us, hi_us, hz, nbits);
        queue_moves(count);
        wait_drained();
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Sender idles lightly, receiver heavily; reset register values.
        // Directed ticks walk the corners starting from angle zero.
        queue_tick(0, 0, 5);          // already at target
        queue_tick(180, 0, 255);      // large step up, clamp at 180
        queue_tick(180, 0, 1);        // reached at the top
        queue_tick(255, 0, 255);      // target above range, angle stays at 180
        queue_tick(255, 255, 0);      // widest tolerance
        queue_tick(0, 0, 255);        // large step down, clamp at zero
        queue_tick(100, 0, 0);        // zero step while not reached
        queue_tick(100, 0, 70);
        queue_tick(100, 0, 70);       // overshoot past target
        queue_tick(100, 0, 70);       // step back
        queue_tick(100, 30, 70);      // distance equals tolerance
        queue_tick(100, 29, 1);       // distance just above tolerance
        queue_tick(90, 19, 200);
        queue_tick(0, 70, 3);
        queue_tick(181, 0, 181);
        queue_tick(170, 9, 10);
        queue_tick(170, 0, 0);
        queue_tick(85, 128, 128);
        queue_tick(0, 0, 128);
        queue_tick(0, 0, 42);
        queue_tick(255, 254, 255);
        queue_tick(90, 0, 90);
        queue_moves(250);
        wait_drained();
        run_setting(0, 20000, 1000, 20, 150);   // widest span, 1000 Hz

        // Swap idling: sender idles heavily, receiver lightly
        src_idle_pct  = 78;
        sink_idle_pct = 24;
        run_setting(20000, 0, 1, 1, 150);       // reversed limits, lowest nonzero frequency
        run_setting(1000, 2000, 333, 0, 100);   // zero resolution
        run_setting(700, 2300, 0, 31, 100);     // zero frequency, oversize resolution
        run_setting(0, 0, 1023, 25, 100);

        // No idling; the long output stall falls in this stretch
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        repeat (3) begin
            run_setting($urandom_range(0, 20000), $urandom_range(0, 20000),
                        $urandom_range(1, 1000), $urandom_range(1, 20), 150);
        end
        run_setting(500, 2500, 50, 16, 150);

        if (mismatches == 0) begin
            $display("tb_servo_angle_slew_and_duty_unit passed");
        end else begin
            $display("tb_servo_angle_slew_and_duty_unit failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/svo_pkg.sv
hdl/svo_front.sv
hdl/svo_fifo.sv
hdl/svo_back.sv
hdl/servo_angle_slew_and_duty_unit.sv
hdl/svo_checker.sv
dv/tb_servo_angle_slew_and_duty_unit.sv
